// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
// each macro checks one implication on the rising edge of clk, off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SUI_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define SUI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/sui_pkg.sv -----
// ----------------------------------------------------------------------------
// sui_pkg
// Types, codes and sizes shared by the set intersection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sui_pkg;

  // store size and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PROBE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_DONE  = 3'd0,
    STAT_NEW   = 3'd1,
    STAT_AGAIN = 3'd2,
    STAT_MISS  = 3'd3,
    STAT_FULL  = 3'd4
  } status_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_COMMIT
  } bk_state_t;

  // classified command
  typedef struct packed {
    op_t                op;
    logic [DATA_W-1:0]  value;
  } cmd_t;

  // head of the command queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // back end status
  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             scanning;
  } bk_stat_t;

endpackage

`default_nettype wire

// ----- rtl/sui_ram.sv -----
// ----------------------------------------------------------------------------
// sui_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sui_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sui_front.sv -----
// ----------------------------------------------------------------------------
// sui_front
// Accepts input words, classifies the operation and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sui_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_operation,
  input  wire logic signed [sui_pkg::DATA_W-1:0] in_value,
  output sui_pkg::q_head_t                  q_head,
  input  wire logic                         q_pop
);

  sui_pkg::cmd_t            cmd_in;
  sui_pkg::cmd_t            q_mem_r [sui_pkg::Q_DEPTH];
  logic [sui_pkg::Q_AW-1:0] wptr_r, wptr_nxt;
  logic [sui_pkg::Q_AW-1:0] rptr_r, rptr_nxt;
  logic [sui_pkg::Q_CW-1:0] cnt_r, cnt_nxt;
  logic                     push;

  // classify: value only matters for load and probe
  always_comb begin
    cmd_in.op = sui_pkg::op_t'(in_operation);
    unique case (cmd_in.op)
      sui_pkg::OP_LOAD, sui_pkg::OP_PROBE: cmd_in.value = $unsigned(in_value);
      default:                             cmd_in.value = '0;
    endcase
  end

  assign in_ready = (cnt_r != sui_pkg::Q_CW'(sui_pkg::Q_DEPTH));
  assign push     = in_valid && in_ready;

  // pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == sui_pkg::Q_AW'(sui_pkg::Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (q_pop) begin
      rptr_nxt = (rptr_r == sui_pkg::Q_AW'(sui_pkg::Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + sui_pkg::Q_CW'(push) - sui_pkg::Q_CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= cmd_in;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.cmd   = q_mem_r[rptr_r];

endmodule

`default_nettype wire

// ----- rtl/sui_back.sv -----
// ----------------------------------------------------------------------------
// sui_back
// Scans the value store for each load or probe, updates the store and
// reported flags, and holds the result word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sui_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  sui_pkg::q_head_t                   q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_status,
  output logic signed [sui_pkg::DATA_W-1:0]  out_common_value,
  output sui_pkg::bk_stat_t                  stat
);

  sui_pkg::bk_state_t           state_r, state_nxt;
  sui_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [sui_pkg::CNT_W-1:0]    fill_r, fill_nxt;
  logic [sui_pkg::CNT_W-1:0]    issue_r, issue_nxt;
  logic                         pend_r, pend_nxt;
  logic [sui_pkg::ADDR_W-1:0]   pidx_r, pidx_nxt;
  logic                         hit_r, hit_nxt;
  logic [sui_pkg::ADDR_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [sui_pkg::CAPACITY-1:0] flags_r, flags_nxt;
  logic                         out_valid_r, out_valid_nxt;
  sui_pkg::status_t             out_status_r, out_status_nxt;
  logic [sui_pkg::DATA_W-1:0]   out_value_r, out_value_nxt;

  logic                         out_free;
  logic                         head_scan;
  logic                         hit_now;
  logic                         rd_en;
  logic                         scan_end;
  logic                         ram_we;
  logic [sui_pkg::DATA_W-1:0]   ram_rdata;

  assign out_free  = !out_valid_r || out_ready;
  assign head_scan = (q_head.cmd.op == sui_pkg::OP_LOAD) ||
                     (q_head.cmd.op == sui_pkg::OP_PROBE);
  assign hit_now   = pend_r && (ram_rdata == cmd_r.value);
  assign rd_en     = (state_r == sui_pkg::BK_SCAN) && (issue_r < fill_r) && !hit_now;
  assign scan_end  = hit_now || (!rd_en && !pend_r);

  // value store
  sui_ram #(
    .WIDTH(sui_pkg::DATA_W),
    .DEPTH(sui_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_r[sui_pkg::ADDR_W-1:0]),
    .wdata(cmd_r.value),
    .re   (rd_en),
    .raddr(issue_r[sui_pkg::ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sui_pkg::BK_IDLE: begin
        if (q_head.valid && head_scan) begin
          state_nxt = (fill_r == '0) ? sui_pkg::BK_COMMIT : sui_pkg::BK_SCAN;
        end
      end
      sui_pkg::BK_SCAN: begin
        if (scan_end) begin
          state_nxt = sui_pkg::BK_COMMIT;
        end
      end
      sui_pkg::BK_COMMIT: begin
        if (out_free) begin
          state_nxt = sui_pkg::BK_IDLE;
        end
      end
      default: state_nxt = sui_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    cmd_nxt        = cmd_r;
    fill_nxt       = fill_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    pidx_nxt       = pidx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    flags_nxt      = flags_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    unique case (state_r)
      sui_pkg::BK_IDLE: begin
        if (q_head.valid && head_scan) begin
          // start a scan from entry zero
          q_pop     = 1'b1;
          cmd_nxt   = q_head.cmd;
          issue_nxt = '0;
          hit_nxt   = 1'b0;
        end else if (q_head.valid && out_free) begin
          // clear or ignored code: answer at once
          q_pop          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = sui_pkg::STAT_DONE;
          out_value_nxt  = q_head.cmd.value;
          if (q_head.cmd.op == sui_pkg::OP_CLEAR) begin
            fill_nxt  = '0;
            flags_nxt = '0;
          end
        end
      end
      sui_pkg::BK_SCAN: begin
        // one read issued and one entry compared each cycle
        pend_nxt = rd_en;
        pidx_nxt = issue_r[sui_pkg::ADDR_W-1:0];
        if (rd_en) begin
          issue_nxt = issue_r + 1'b1;
        end
        if (hit_now) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = pidx_r;
        end
      end
      sui_pkg::BK_COMMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = cmd_r.value;
          out_status_nxt = sui_pkg::STAT_DONE;
          unique case (cmd_r.op)
            sui_pkg::OP_LOAD: begin
              if (!hit_r) begin
                if (fill_r == sui_pkg::CNT_W'(sui_pkg::CAPACITY)) begin
                  out_status_nxt = sui_pkg::STAT_FULL;
                end else begin
                  ram_we                                 = 1'b1;
                  flags_nxt[fill_r[sui_pkg::ADDR_W-1:0]] = 1'b0;
                  fill_nxt                               = fill_r + 1'b1;
                end
              end
            end
            sui_pkg::OP_PROBE: begin
              if (!hit_r) begin
                out_status_nxt = sui_pkg::STAT_MISS;
              end else if (flags_r[hit_idx_r]) begin
                out_status_nxt = sui_pkg::STAT_AGAIN;
              end else begin
                out_status_nxt       = sui_pkg::STAT_NEW;
                flags_nxt[hit_idx_r] = 1'b1;
              end
            end
            default: out_status_nxt = sui_pkg::STAT_DONE;
          endcase
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sui_pkg::BK_IDLE;
      fill_r      <= '0;
      flags_r     <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      flags_r     <= flags_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    issue_r      <= issue_nxt;
    pidx_r       <= pidx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_common_value = $signed(out_value_r);
  assign stat.fill        = fill_r;
  assign stat.scanning    = (state_r == sui_pkg::BK_SCAN);

endmodule

`default_nettype wire

// ----- rtl/set_intersection_unique_unit.sv -----
// ----------------------------------------------------------------------------
// set_intersection_unique_unit
// Unique set intersection engine with a 64-entry value store.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel: one word per item, in_operation 0 load, 1 probe, 2 clear.
//   out_* channel: exactly one result word per input word, in order, with a
//   status code and the echoed value (zero for clear and unused codes).
//   A front queue of two words takes input while the back end works, so
//   the sender only stalls when both queue slots are occupied.
//   Load and probe search the store one entry per cycle through the single
//   read port of the store RAM, stopping at the first match; clear and the
//   unused code skip the search. The back end finishes one word before it
//   takes the next from the queue head.
//   Reset empties the store and the queue; no clearing pass is needed.
//   When the receiver stalls, the result holds in the output register and
//   the back end waits before it commits its next result; the queue still fills.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module set_intersection_unique_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_operation,
  input  wire logic signed [sui_pkg::DATA_W-1:0]   in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [2:0]                               out_status,
  output logic signed [sui_pkg::DATA_W-1:0]        out_common_value
);

  sui_pkg::q_head_t  q_head;
  logic              q_pop;
  sui_pkg::bk_stat_t stat;

  // front: accept and classify
  sui_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_value    (in_value),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  // back: search, update and answer
  sui_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_common_value(out_common_value),
    .stat            (stat)
  );

  // checks
  `SUI_ASSERT_NOW(a_fill_bound, 1'b1, stat.fill <= sui_pkg::CNT_W'(sui_pkg::CAPACITY))
  `SUI_ASSERT_NOW(a_full_only_when_full, out_valid && (out_status == sui_pkg::STAT_FULL),
                  stat.fill == sui_pkg::CNT_W'(sui_pkg::CAPACITY))
  `SUI_ASSERT_NOW(a_scan_needs_entries, stat.scanning, stat.fill != '0)
  `SUI_ASSERT_NEXT(a_accept_queues, in_valid && in_ready, q_head.valid)

endmodule

`default_nettype wire

// ----- tb/sv/set_intersection_unique_unit_test.sv -----
// ----------------------------------------------------------------------------
// set_intersection_unique_unit_test
// Drives load, probe, clear and unused-code words into the set intersection
// unit and checks every result word against a shadow copy of the value store
// and its reported flags. A short directed run covers the value extremes and
// each status but full; random load/probe sequences follow, some of them
// large enough to overflow the store, with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module set_intersection_unique_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    sui_pkg::op_t                      op;
    logic signed [sui_pkg::DATA_W-1:0] value;
  } set_word_t;

  typedef struct {
    sui_pkg::status_t                  status;
    logic signed [sui_pkg::DATA_W-1:0] common_value;
  } verdict_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [1:0]                        in_operation = 2'd0;
  logic signed [sui_pkg::DATA_W-1:0] in_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [2:0]                        out_status;
  logic signed [sui_pkg::DATA_W-1:0] out_common_value;

  // words waiting to be sent and verdicts owed by the unit
  set_word_t set_words[$];
  verdict_t  owed_verdicts[$];
  set_word_t presented;
  int        words_made = 0;
  int        fault_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  // shadow of the value store
  logic [sui_pkg::DATA_W-1:0] shadow_store[sui_pkg::CAPACITY];
  bit                         shadow_reported[sui_pkg::CAPACITY];
  int                         shadow_fill = 0;

  set_intersection_unique_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_common_value (out_common_value)
  );

  always #2 clk = ~clk;

  // index of the stored entry holding a value, -1 when none does
  function automatic int find_stored(logic [sui_pkg::DATA_W-1:0] value);
    for (int k = 0; k < shadow_fill; k++) begin
      if (shadow_store[k] == value) return k;
    end
    return -1;
  endfunction

  // apply one word to the shadow store and return the verdict it earns
  function automatic verdict_t intersect_word(set_word_t w);
    verdict_t v;
    int       hit;
    v.status = sui_pkg::STAT_DONE;
    v.common_value = w.value;
    case (w.op)
      sui_pkg::OP_LOAD: begin
        hit = find_stored(w.value);
        if (hit < 0) begin
          if (shadow_fill >= sui_pkg::CAPACITY) begin
            v.status = sui_pkg::STAT_FULL;
          end else begin
            shadow_store[shadow_fill] = w.value;
            shadow_reported[shadow_fill] = 1'b0;
            shadow_fill++;
          end
        end
      end
      sui_pkg::OP_PROBE: begin
        hit = find_stored(w.value);
        if (hit < 0) begin
          v.status = sui_pkg::STAT_MISS;
        end else if (shadow_reported[hit]) begin
          v.status = sui_pkg::STAT_AGAIN;
        end else begin
          shadow_reported[hit] = 1'b1;
          v.status = sui_pkg::STAT_NEW;
        end
      end
      sui_pkg::OP_CLEAR: begin
        shadow_fill = 0;
        foreach (shadow_reported[i]) shadow_reported[i] = 1'b0;
        v.common_value = '0;
      end
      default: begin
        v.common_value = '0;
      end
    endcase
    return v;
  endfunction

  // mix of full-range, small positive and small negative values
  function automatic logic signed [sui_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(2))
      0: return $urandom;
      1: return $urandom_range(15);
      default: return 32'hFFFF_FFF0 | $urandom_range(15);
    endcase
  endfunction

  task automatic add_word(sui_pkg::op_t op, logic signed [sui_pkg::DATA_W-1:0] value);
    set_word_t w;
    w.op = op;
    w.value = value;
    set_words.insert(set_words.size(), w);
    words_made++;
  endtask

  // random load/probe sequences, some of them overflowing the store
  task automatic build_phase(int quota);
    int                                stop_at;
    int                                n_loads;
    int                                n_probes;
    logic signed [sui_pkg::DATA_W-1:0] v;
    logic signed [sui_pkg::DATA_W-1:0] loaded[$];
    stop_at = words_made + quota;
    while (words_made < stop_at) begin
      // most sequences start from an empty store, the rest pile on
      if ($urandom_range(4) != 0) begin
        add_word(sui_pkg::OP_CLEAR, $urandom);
        loaded.delete();
      end
      if ($urandom_range(3) == 0)
        n_loads = $urandom_range(sui_pkg::CAPACITY + 8, sui_pkg::CAPACITY);
      else n_loads = $urandom_range(24, 1);
      repeat (n_loads) begin
        if (loaded.size() > 0 && $urandom_range(5) == 0)
          v = loaded[$urandom_range(loaded.size() - 1)];
        else
          v = random_value();
        add_word(sui_pkg::OP_LOAD, v);
        loaded.insert(loaded.size(), v);
      end
      n_probes = $urandom_range(30, 1);
      repeat (n_probes) begin
        if ($urandom_range(9) == 0)
          add_word(sui_pkg::op_t'($urandom_range(3)), random_value());
        else if (loaded.size() > 0 && $urandom_range(9) < 6)
          add_word(sui_pkg::OP_PROBE, loaded[$urandom_range(loaded.size() - 1)]);
        else
          add_word(sui_pkg::OP_PROBE, random_value());
      end
    end
  endtask

  task automatic drain_backlog();
    while (set_words.size() != 0 || in_valid) @(posedge clk);
  endtask

  // driver: predicts each accepted word, then presents the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        owed_verdicts.insert(owed_verdicts.size(), intersect_word(presented));
      if (!in_valid || in_ready) begin
        if (set_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          presented = set_words.pop_front();
          in_valid <= 1'b1;
          in_operation <= presented.op;
          in_value <= presented.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result word with the oldest owed verdict
  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_verdicts.size() == 0) begin
          $error("result word with nothing owed: status %0d value %h",
                 out_status, out_common_value);
          fault_count++;
        end else begin
          want = owed_verdicts.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            fault_count++;
          end
          if (out_common_value !== want.common_value) begin
            $error("common_value: expected %h, actual %h",
                   want.common_value, out_common_value);
            fault_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: sender idles a quarter of the time, receiver nearly half
    send_idle_pct = 26;
    recv_idle_pct = 45;

    // directed: extremes, duplicates, every status but full, clear and the unused code
    add_word(sui_pkg::OP_PROBE, 32'sd0);
    add_word(sui_pkg::OP_LOAD, 32'h8000_0000);
    add_word(sui_pkg::OP_LOAD, 32'h7FFF_FFFF);
    add_word(sui_pkg::OP_LOAD, 32'h0000_0000);
    add_word(sui_pkg::OP_LOAD, 32'hFFFF_FFFF);
    add_word(sui_pkg::OP_LOAD, 32'h8000_0000);
    add_word(sui_pkg::OP_PROBE, 32'h7FFF_FFFF);
    add_word(sui_pkg::OP_PROBE, 32'h7FFF_FFFF);
    add_word(sui_pkg::OP_PROBE, 32'h8000_0000);
    add_word(sui_pkg::OP_PROBE, 32'h0000_0001);
    add_word(sui_pkg::OP_PROBE, 32'hFFFF_FFFF);
    add_word(sui_pkg::OP_NOP, 32'h5A5A_5A5A);
    add_word(sui_pkg::OP_CLEAR, 32'h1234_5678);
    add_word(sui_pkg::OP_PROBE, 32'h7FFF_FFFF);
    add_word(sui_pkg::OP_LOAD, 32'h7FFF_FFFF);
    add_word(sui_pkg::OP_PROBE, 32'h7FFF_FFFF);
    add_word(sui_pkg::OP_PROBE, 32'h0000_0000);
    add_word(sui_pkg::OP_CLEAR, 32'hFFFF_FFFF);

    build_phase(430);
    drain_backlog();

    // phase two: the stall rates swap sides
    send_idle_pct = 45;
    recv_idle_pct = 26;
    build_phase(430);
    drain_backlog();

    // phase three: back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    build_phase(430);
    drain_backlog();

    while (owed_verdicts.size() != 0) @(posedge clk);
    // a full store scan plus margin, so stray words still show up
    repeat (100) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
